FILE: hw/rtl/mkd_pkg.sv
// shared types, constants and letter table for the morse key decoder
package mkd_pkg;

  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SYM_W      = 4;
  localparam int CNT_W      = 3;
  localparam int CODE_W     = 7;
  localparam int LETTERS    = 26;

  localparam logic [CFG_IDX_W-1:0] CFG_DOT_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LETTER_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_GAP      = 2'd2;

  localparam logic [CFG_W-1:0] DOT_THRESHOLD_RST = 16'd250;
  localparam logic [CFG_W-1:0] LETTER_GAP_RST    = 16'd750;
  localparam logic [CFG_W-1:0] WORD_GAP_RST      = 16'd1750;

  localparam logic [CNT_W-1:0]  MAX_SYMBOLS  = 3'd4;
  localparam logic [CNT_W-1:0]  TOO_LONG     = 3'd5;
  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 7'd63;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 7'd32;
  localparam logic [CODE_W-1:0] CODE_A       = 7'd65;

  // symbol patterns A..Z, first symbol in bit 0, dash is 1
  localparam logic [SYM_W-1:0] LETTER_BITS [LETTERS] = '{
    4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
    4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
  };
  localparam logic [CNT_W-1:0] LETTER_LEN [LETTERS] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };

  typedef enum logic [1:0] {
    EV_PRESS_FIRST,
    EV_PRESS_HOLD,
    EV_RELEASE,
    EV_IDLE
  } ev_kind_t;

  // one classified tick handed from front to back
  typedef struct packed {
    ev_kind_t kind;
    logic     dash;
    logic     letter_hit;
    logic     word_hit;
  } mkd_evt_t;

  function automatic logic [CODE_W-1:0] decode_letter(input logic [SYM_W-1:0] bits,
                                                      input logic [CNT_W-1:0] count);
    logic [CODE_W-1:0] code;
    code = CODE_UNKNOWN;
    for (int i = 0; i < LETTERS; i++) begin
      if (LETTER_LEN[i] == count && LETTER_BITS[i] == bits) begin
        code = CODE_A + CODE_W'(i);
      end
    end
    return code;
  endfunction

endpackage

FILE: hw/rtl/mkd_if.sv
// valid/ready channel interfaces for key ticks and decoder results
interface mkd_in_if;
  logic valid;
  logic ready;
  logic key_level;
  modport source (output valid, output key_level, input ready);
  modport sink   (input valid, input key_level, output ready);
endinterface

interface mkd_out_if;
  logic       valid;
  logic       ready;
  logic       char_valid;
  logic [6:0] char_code;
  logic [3:0] live_symbols;
  logic [2:0] live_count;
  modport source (output valid, output char_valid, output char_code,
                  output live_symbols, output live_count, input ready);
  modport sink   (input valid, input char_valid, input char_code,
                  input live_symbols, input live_count, output ready);
endinterface

FILE: hw/rtl/mkd_front.sv
// front end: key timers, config registers and tick classification
module mkd_front #(
  parameter int TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mkd_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_fire,
  input  logic                           key_level,
  output mkd_pkg::mkd_evt_t              evt
);
  import mkd_pkg::*;

  localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

  logic [CFG_W-1:0]      dot_thr_r, char_gap_r, space_gap_r;
  logic                  key_down_r, key_down_nxt;
  logic [TIMER_BITS-1:0] press_r, press_nxt;
  logic [TIMER_BITS-1:0] idle_r, idle_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_thr_r   <= DOT_THRESHOLD_RST;
      char_gap_r  <= LETTER_GAP_RST;
      space_gap_r <= WORD_GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DOT_THRESHOLD: dot_thr_r   <= cfg_data;
        CFG_LETTER_GAP:    char_gap_r  <= cfg_data;
        CFG_WORD_GAP:      space_gap_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    key_down_nxt = key_level;
    press_nxt    = press_r;
    idle_nxt     = idle_r;
    evt.dash     = 1'b0;
    if (key_level) begin
      if (!key_down_r) begin
        evt.kind  = EV_PRESS_FIRST;
        press_nxt = TIMER_BITS'(1);
      end else begin
        evt.kind  = EV_PRESS_HOLD;
        press_nxt = (press_r == TIMER_MAX) ? TIMER_MAX : press_r + 1'b1;
      end
    end else if (key_down_r) begin
      evt.kind  = EV_RELEASE;
      evt.dash  = CMP_W'(press_r) >= CMP_W'(dot_thr_r);
      press_nxt = '0;
      idle_nxt  = '0;
    end else begin
      evt.kind = EV_IDLE;
      idle_nxt = (idle_r == TIMER_MAX) ? TIMER_MAX : idle_r + 1'b1;
    end
    evt.letter_hit = CMP_W'(idle_nxt) > CMP_W'(char_gap_r);
    evt.word_hit   = CMP_W'(idle_nxt) > CMP_W'(space_gap_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_down_r <= 1'b0;
      press_r    <= '0;
      idle_r     <= '0;
    end else if (in_fire) begin
      key_down_r <= key_down_nxt;
      press_r    <= press_nxt;
      idle_r     <= idle_nxt;
    end
  end

endmodule

FILE: hw/rtl/mkd_queue.sv
// two-entry queue of classified ticks between front and back
module mkd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mkd_pkg::mkd_evt_t push_evt,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output mkd_pkg::mkd_evt_t head_evt
);
  import mkd_pkg::*;

  mkd_evt_t   entry_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = count_r == 2'd2;
  assign head_valid = count_r != 2'd0;
  assign head_evt   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: hw/rtl/mkd_back.sv
// back end: symbol buffer, letter decode, word space and result register
module mkd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              evt_valid,
  input  mkd_pkg::mkd_evt_t evt,
  output logic              pop,
  mkd_out_if.source         out_ch
);
  import mkd_pkg::*;

  logic [SYM_W-1:0]  sym_r, sym_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              space_r, space_nxt;
  logic              out_valid_r;
  logic              char_valid_r, char_valid_nxt;
  logic [CODE_W-1:0] code_r, code_nxt;
  logic              released;

  assign pop = evt_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    sym_nxt        = sym_r;
    cnt_nxt        = cnt_r;
    space_nxt      = space_r;
    char_valid_nxt = 1'b0;
    code_nxt       = '0;
    unique case (evt.kind)
      EV_PRESS_FIRST: space_nxt = 1'b0;
      EV_PRESS_HOLD:  ;
      EV_RELEASE: begin
        if (cnt_r < MAX_SYMBOLS) begin
          if (evt.dash) sym_nxt[cnt_r[1:0]] = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end else begin
          cnt_nxt = TOO_LONG;
        end
      end
      EV_IDLE: ;
    endcase
    released = (evt.kind == EV_RELEASE) || (evt.kind == EV_IDLE);
    if (released) begin
      if (cnt_nxt != '0 && evt.letter_hit) begin
        code_nxt       = decode_letter(sym_nxt, cnt_nxt);
        char_valid_nxt = 1'b1;
        sym_nxt        = '0;
        cnt_nxt        = '0;
        space_nxt      = 1'b1;
      end else if (cnt_nxt == '0 && space_nxt && evt.word_hit) begin
        code_nxt       = CODE_SPACE;
        char_valid_nxt = 1'b1;
        space_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r       <= '0;
      cnt_r       <= '0;
      space_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        sym_r       <= sym_nxt;
        cnt_r       <= cnt_nxt;
        space_r     <= space_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      char_valid_r <= char_valid_nxt;
      code_r       <= code_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.char_valid   = char_valid_r;
  assign out_ch.char_code    = code_r;
  assign out_ch.live_symbols = sym_r;
  assign out_ch.live_count   = cnt_r;

endmodule

FILE: hw/rtl/morse_key_decoder.sv
// an accepted tick beat is written into the two-entry queue, then popped into the result register
// throughput: one tick per cycle; the front accepts while the two-entry queue has room
// the back end takes one queued tick per cycle whenever the result register is free
// reset: synchronous active-low; clears timers, symbols, queue and result valid
// config registers return to 250, 750 and 1750 ticks
module morse_key_decoder #(
  parameter int TIMER_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mkd_pkg::CFG_W-1:0]      cfg_data,
  mkd_in_if.sink                         in_ch,
  mkd_out_if.source                      out_ch
);
  import mkd_pkg::*;

  mkd_evt_t front_evt, head_evt;
  logic     q_full, q_head_valid, q_pop, in_fire;

  assign in_ch.ready = !q_full;
  assign in_fire     = in_ch.valid && !q_full;

  mkd_front #(.TIMER_BITS(TIMER_BITS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_fire   (in_fire),
    .key_level (in_ch.key_level),
    .evt       (front_evt)
  );

  mkd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_fire),
    .push_evt   (front_evt),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_evt   (head_evt)
  );

  mkd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .evt_valid (q_head_valid),
    .evt       (head_evt),
    .pop       (q_pop),
    .out_ch    (out_ch)
  );

endmodule

FILE: hw/rtl/mkd_checker.sv
// port-level assertions for the morse key decoder, bound to the top level
module mkd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       char_valid,
  input logic [6:0] char_code,
  input logic [3:0] live_symbols,
  input logic [2:0] live_count
);
  import mkd_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(char_valid)
      && $stable(live_symbols) && $stable(live_count))
    else $error("stalled result changed");

  a_quiet_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !char_valid |-> char_code == 7'd0)
    else $error("code without character");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && char_valid |-> char_code == CODE_SPACE || char_code == CODE_UNKNOWN
      || (char_code >= CODE_A && char_code <= CODE_A + 7'(LETTERS - 1)))
    else $error("emitted code out of alphabet");

  a_live_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> live_count <= TOO_LONG && (live_count != 3'd0 || live_symbols == 4'd0)
      && (!char_valid || live_count == 3'd0))
    else $error("held symbols inconsistent");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .char_valid   (out_ch.char_valid),
  .char_code    (out_ch.char_code),
  .live_symbols (out_ch.live_symbols),
  .live_count   (out_ch.live_count)
);
